// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FPMV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FPMV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fpmv_pkg.sv -----
// Shared constants and types of the fixed-point matrix-vector layer.
`timescale 1ns / 1ps
`default_nettype none
package fpmv_pkg;

    // Store and layer dimensions
    localparam int VEC_DEPTH = 256;
    localparam int MAX_ROWS  = 256;
    localparam int ADDR_W    = $clog2(VEC_DEPTH);
    localparam int CNT_W     = $clog2(VEC_DEPTH + 1);
    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCNT_W    = $clog2(MAX_ROWS + 1);

    // Field widths
    localparam int DATA_W    = 32;
    localparam int SHIFT_W   = 5;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAC_SHIFT = 2'd0,
        CFG_ROW_LENGTH = 2'd1,
        CFG_ROW_COUNT  = 2'd2
    } cfg_idx_t;

    // Item modes
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_WEIGHT = 1'b1;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clear;
    } mac_ctrl_t;

endpackage
`default_nettype wire

// ----- src/fpmv_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fpmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/fpmv_mac.sv -----
// Multiply, fixed-point shift and wrapping accumulate for one weight at a time.
`timescale 1ns / 1ps
`default_nettype none
module fpmv_mac import fpmv_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mac_ctrl_t          ctrl,
    input  wire logic [DATA_W-1:0]  weight,
    input  wire logic [DATA_W-1:0]  elem,
    input  wire logic [SHIFT_W-1:0] frac_shift,
    output logic      [DATA_W-1:0]  sum_next
);

    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] shifted;

    // Product register: low word of the product only
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= weight * elem;
        end
    end

    // Arithmetic shift to the decimal point, then add with wrap
    assign shifted  = DATA_W'($signed(prod_reg) >>> frac_shift);
    assign sum_next = acc_reg + shifted;

    // Accumulator, cleared once a row is done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= ctrl.acc_clear ? '0 : sum_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/fixed_point_matrix_vector_layer.sv -----
// Load item: written straight into the vector store; next item taken at once.
// Weight item: store read, multiply, shift-accumulate; no new item is taken until it is accumulated.
// A row result is registered when its final weight is accumulated and held until taken.
// The input side stalls only while a weight is at work or a finished row finds the output full.
// Reset clears counters, accumulator, output valid and sets registers to 0, 1, 1.
// The vector store is not cleared; entries hold nothing defined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_matrix_vector_layer import fpmv_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // input items
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 mode,
    input  wire logic [7:0]           position,
    input  wire logic signed [31:0]   value,
    // result items
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                row_index,
    output logic signed [31:0]        dot_sum,
    output logic                      last_row
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC
    } state_t;

    state_t state_reg;

    logic [SHIFT_W-1:0] frac_shift_reg;
    logic [CFG_W-1:0]   row_length_reg;
    logic [CFG_W-1:0]   row_count_reg;

    logic [CNT_W-1:0]   elem_cnt_reg;
    logic [CNT_W-1:0]   elem_cnt_next;
    logic [ROW_W-1:0]   row_cnt_reg;
    logic [ROW_W-1:0]   row_cnt_next;
    logic [DATA_W-1:0]  weight_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         row_index_reg;
    logic [DATA_W-1:0]  dot_sum_reg;
    logic               last_row_reg;

    logic [CNT_W-1:0]   len_eff;
    logic [RCNT_W-1:0]  cnt_eff;
    logic               accept;
    logic               row_done;
    logic               is_last;
    logic               out_free;
    logic               out_set;
    logic               acc_go;
    logic               load_we;
    logic [DATA_W-1:0]  elem;
    logic [DATA_W-1:0]  sum_next;
    mac_ctrl_t          mac_ctrl;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_shift_reg <= '0;
            row_length_reg <= CFG_W'(1);
            row_count_reg  <= CFG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAC_SHIFT: frac_shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_ROW_LENGTH: row_length_reg <= cfg_data;
                CFG_ROW_COUNT:  row_count_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Out-of-range lengths: zero counts as one, large values saturate
    always_comb
    begin
        if (row_length_reg == '0)
            len_eff = CNT_W'(1);
        else if (32'(row_length_reg) > 32'(VEC_DEPTH))
            len_eff = CNT_W'(VEC_DEPTH);
        else
            len_eff = CNT_W'(row_length_reg);

        if (row_count_reg == '0)
            cnt_eff = RCNT_W'(1);
        else if (32'(row_count_reg) > 32'(MAX_ROWS))
            cnt_eff = RCNT_W'(MAX_ROWS);
        else
            cnt_eff = RCNT_W'(row_count_reg);
    end

    // Handshake and row bookkeeping
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign load_we   = accept && (mode == MODE_LOAD) && (32'(position) < 32'(VEC_DEPTH));

    assign row_done  = (32'(elem_cnt_reg) + 32'd1) >= 32'(len_eff);
    assign is_last   = (32'(row_cnt_reg) + 32'd1) >= 32'(cnt_eff);
    assign out_free  = !out_valid_reg || !out_stall;
    assign acc_go    = (state_reg == S_ACC) && (!row_done || out_free);
    assign out_set   = acc_go && row_done;

    // Output valid: set by a finished row, held while stalled
    assign out_valid_next = out_set || (out_valid_reg && out_stall);

    assign elem_cnt_next = row_done ? '0 : CNT_W'(elem_cnt_reg + 1'b1);
    assign row_cnt_next  = is_last ? '0 : ROW_W'(row_cnt_reg + 1'b1);

    assign mac_ctrl = '{
        mul_en:    (state_reg == S_MUL),
        acc_en:    acc_go,
        acc_clear: row_done
    };

    // Vector store
    fpmv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VEC_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_we),
        .waddr (ADDR_W'(position)),
        .wdata (DATA_W'(value)),
        .re    (accept && (mode == MODE_WEIGHT)),
        .raddr (elem_cnt_reg[ADDR_W-1:0]),
        .rdata (elem)
    );

    // Multiply-accumulate
    fpmv_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .weight     (weight_reg),
        .elem       (elem),
        .frac_shift (frac_shift_reg),
        .sum_next   (sum_next)
    );

    // Sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            elem_cnt_reg  <= '0;
            row_cnt_reg   <= '0;
            weight_reg    <= '0;
            out_valid_reg <= 1'b0;
            row_index_reg <= '0;
            dot_sum_reg   <= '0;
            last_row_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (mode == MODE_WEIGHT))
                    begin
                        weight_reg <= DATA_W'(value);
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (acc_go)
                    begin
                        elem_cnt_reg <= elem_cnt_next;
                        state_reg    <= S_IDLE;
                        if (row_done)
                        begin
                            row_index_reg <= 8'(row_cnt_reg);
                            dot_sum_reg   <= sum_next;
                            last_row_reg  <= is_last;
                            row_cnt_reg   <= row_cnt_next;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_index_reg;
    assign dot_sum   = $signed(dot_sum_reg);
    assign last_row  = last_row_reg;

endmodule
`default_nettype wire

// ----- src/fpmv_checker.sv -----
// Port-level checks of the matrix-vector layer and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fpmv_checker import fpmv_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic                 mode,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [7:0]           row_index,
    input wire logic signed [31:0]   dot_sum,
    input wire logic                 last_row
);

    // A stalled result keeps its payload
    `FPMV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(dot_sum) && $stable(row_index) && $stable(last_row), "stalled result changed")

    // An accepted weight keeps the input side busy through the multiply and accumulate states
    `FPMV_ASSERT(a_weight_busy, in_valid && !in_stall && mode |=> in_stall ##1 in_stall, "weight not given its cycles")

    // A load never stalls the next item
    `FPMV_ASSERT(a_load_free, in_valid && !in_stall && !mode |=> !in_stall, "load stalled input")

    // No result shows while reset is held
    `FPMV_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result during reset")

endmodule

bind fixed_point_matrix_vector_layer fpmv_checker u_fpmv_checker (.*);
`default_nettype wire
